>>> design/sfr_pkg.sv
package sfr_pkg;

    // Table geometry
    localparam int GLYPH_COUNT = 128;
    localparam int MAX_STROKES = 32;
    localparam int CODE_BITS   = 7;
    localparam int SLOT_BITS   = 5;
    localparam int ADDR_BITS   = CODE_BITS + SLOT_BITS;
    localparam int TABLE_DEPTH = GLYPH_COUNT * MAX_STROKES;
    localparam int ENTRY_BITS  = 18;

    // Pen coordinates and the internal working word of the shared adder
    localparam int COORD_BITS  = 16;
    localparam int DW          = 20;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;

    // Request actions
    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_CHAR  = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;

    // Stroke opcodes
    localparam logic [1:0] OP_END  = 2'd0;
    localparam logic [1:0] OP_DRAW = 2'd2;
    localparam logic [1:0] OP_MOVE = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHAR_WIDTH = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHAR_HEIGHT= 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FONT_SIZE  = 3'd4;

    typedef logic signed [DW-1:0]         word_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [12:0] window_width;
        logic [12:0] window_height;
        logic [6:0]  base_char_width;
        logic [6:0]  base_char_height;
        logic        font_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic [7:0]         str_length;
        logic [6:0]         char_code;
        logic [4:0]         stroke_index;
        logic [1:0]         stroke_op;
        logic signed [7:0]  stroke_dx;
        logic signed [7:0]  stroke_dy;
    } item_t;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] z;
        logic               last;
    } seg_t;

    // Shared adder request: sum = a + (inv ? ~b : b) + cin
    typedef struct packed {
        word_t a;
        word_t b;
        logic  inv;
        logic  cin;
    } alu_req_t;

    typedef struct packed {
        word_t sum;
        logic  neg;
        logic  zero;
    } alu_res_t;

endpackage

>>> design/sfr_ifs.sv
interface sfr_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic [7:0]         str_length;
    logic [6:0]         char_code;
    logic [4:0]         stroke_index;
    logic [1:0]         stroke_op;
    logic signed [7:0]  stroke_dx;
    logic signed [7:0]  stroke_dy;

    modport source (
        output valid, action, start_x, start_y, start_z, str_length,
               char_code, stroke_index, stroke_op, stroke_dx, stroke_dy,
        input  ready
    );
    modport sink (
        input  valid, action, start_x, start_y, start_z, str_length,
               char_code, stroke_index, stroke_op, stroke_dx, stroke_dy,
        output ready
    );
endinterface

interface sfr_seg_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] seg_x0;
    logic signed [15:0] seg_y0;
    logic signed [15:0] seg_x1;
    logic signed [15:0] seg_y1;
    logic signed [15:0] seg_z;
    logic               last_segment;

    modport source (
        output valid, seg_x0, seg_y0, seg_x1, seg_y1, seg_z, last_segment,
        input  ready
    );
    modport sink (
        input  valid, seg_x0, seg_y0, seg_x1, seg_y1, seg_z, last_segment,
        output ready
    );
endinterface

interface sfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/sfr_stroke_mem.sv
module sfr_stroke_mem
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_BITS-1:0]  waddr,
    input  logic [ENTRY_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0]  raddr,
    output logic [ENTRY_BITS-1:0] rdata_reg
);

    logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

endmodule

>>> design/sfr_alu.sv
module sfr_alu
    import sfr_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    word_t b_op;

    // Add or subtract with carry in, flag sign and zero
    always_comb
    begin
        b_op     = req.inv ? ~req.b : req.b;
        res.sum  = req.a + b_op + word_t'(req.cin);
        res.neg  = res.sum[DW-1];
        res.zero = (res.sum == '0);
    end

endmodule

>>> design/sfr_ctrl.sv
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg_q,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item_d,
    output logic                  seg_valid,
    input  logic                  seg_ready,
    output seg_t                  seg_d,
    output logic                  mem_we,
    output logic [ADDR_BITS-1:0]  mem_waddr,
    output logic [ENTRY_BITS-1:0] mem_wdata,
    output logic [ADDR_BITS-1:0]  mem_raddr,
    input  logic [ENTRY_BITS-1:0] mem_rdata,
    output alu_req_t              alu_req,
    input  alu_res_t              alu_res
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_BY0   = 4'd2;
    localparam logic [3:0] S_BNEAR = 4'd3;
    localparam logic [3:0] S_BDOWN = 4'd4;
    localparam logic [3:0] S_BY1   = 4'd5;
    localparam logic [3:0] S_BX    = 4'd6;
    localparam logic [3:0] S_BMUL  = 4'd7;
    localparam logic [3:0] S_BSKIP = 4'd8;
    localparam logic [3:0] S_BTRIM = 4'd9;
    localparam logic [3:0] S_BSUB  = 4'd10;
    localparam logic [3:0] S_DRD   = 4'd11;
    localparam logic [3:0] S_DOP   = 4'd12;
    localparam logic [3:0] S_DY    = 4'd13;
    localparam logic [3:0] S_DPUSH = 4'd14;
    localparam logic [3:0] S_DEND  = 4'd15;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MAX_STROKES - 1);

    // Control state
    logic [3:0]           state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [2:0]           bit_reg, bit_next;
    logic [7:0]           len_reg, len_next;
    logic [7:0]           skip_reg, skip_next;
    logic [7:0]           skip_cnt_reg, skip_cnt_next;
    logic [7:0]           render_cnt_reg, render_cnt_next;
    logic [7:0]           char_pos_reg, char_pos_next;
    logic                 visible_reg, visible_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;
    coord_t               pen_x_reg, pen_x_next;
    coord_t               pen_y_reg, pen_y_next;
    coord_t               pen_z_reg, pen_z_next;

    // Datapath
    word_t                ox_reg, ox_next;
    word_t                oy_reg, oy_next;
    word_t                acc_reg, acc_next;
    coord_t               z_reg, z_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [1:0]           op_reg, op_next;
    logic signed [7:0]    dy_reg, dy_next;
    coord_t               x1_reg, x1_next;
    seg_t                 new_reg, new_next;
    seg_t                 pend_reg, pend_next;
    seg_t                 out_reg, out_next;

    logic [7:0]           chw;
    logic [7:0]           chh;
    word_t                win_w;
    word_t                win_h;
    word_t                sdx;
    word_t                sdy;
    logic signed [7:0]    ent_dx;
    logic [1:0]           ent_op;
    logic                 out_free;
    logic                 accept;
    logic [3:0]           adv_state;
    logic [SLOT_BITS-1:0] adv_idx;
    logic                 char_live;

    // Cell size, window edges and scaled stroke offsets
    always_comb
    begin
        chw    = cfg_q.font_size ? {cfg_q.base_char_width, 1'b0}
                                 : {1'b0, cfg_q.base_char_width};
        chh    = cfg_q.font_size ? {cfg_q.base_char_height, 1'b0}
                                 : {1'b0, cfg_q.base_char_height};
        win_w  = word_t'(cfg_q.window_width);
        win_h  = word_t'(cfg_q.window_height);
        ent_dx = mem_rdata[7:0];
        ent_op = mem_rdata[17:16];
        sdx    = cfg_q.font_size ? (word_t'(ent_dx) <<< 1) : word_t'(ent_dx);
        sdy    = cfg_q.font_size ? (word_t'(dy_reg) <<< 1) : word_t'(dy_reg);
    end

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || seg_ready;
    assign seg_valid  = out_valid_reg;
    assign seg_d      = out_reg;
    assign mem_raddr  = {code_reg, idx_reg};
    assign char_live  = ({1'b0, char_pos_reg} <
                         ({1'b0, skip_cnt_reg} + {1'b0, render_cnt_reg}));

    // Step to the next stroke slot or finish the walk
    always_comb
    begin
        if (idx_reg == LAST_SLOT)
        begin
            adv_state = S_DEND;
            adv_idx   = idx_reg;
        end
        else
        begin
            adv_state = S_DRD;
            adv_idx   = idx_reg + 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        bit_next        = bit_reg;
        len_next        = len_reg;
        skip_next       = skip_reg;
        skip_cnt_next   = skip_cnt_reg;
        render_cnt_next = render_cnt_reg;
        char_pos_next   = char_pos_reg;
        visible_next    = visible_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !seg_ready;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        pen_z_next      = pen_z_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        acc_next        = acc_reg;
        z_next          = z_reg;
        code_next       = code_reg;
        op_next         = op_reg;
        dy_next         = dy_reg;
        x1_next         = x1_reg;
        new_next        = new_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = {item_d.char_code, item_d.stroke_index};
        mem_wdata       = {item_d.stroke_op, item_d.stroke_dy, item_d.stroke_dx};
        alu_req         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the stroke table to end-of-glyph entries
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (item_d.action)
                        ACT_BEGIN:
                        begin
                            ox_next         = word_t'(item_d.start_x);
                            oy_next         = word_t'(item_d.start_y);
                            z_next          = coord_t'(item_d.start_z);
                            len_next        = item_d.str_length;
                            skip_next       = '0;
                            visible_next    = 1'b0;
                            skip_cnt_next   = '0;
                            render_cnt_next = '0;
                            char_pos_next   = '0;
                            state_next      = S_BY0;
                        end
                        ACT_CHAR:
                        begin
                            if (visible_reg)
                            begin
                                if (char_pos_reg < skip_cnt_reg)
                                begin
                                    char_pos_next = char_pos_reg + 1'b1;
                                end
                                else if (char_live)
                                begin
                                    char_pos_next = char_pos_reg + 1'b1;
                                    code_next     = item_d.char_code;
                                    idx_next      = '0;
                                    state_next    = S_DRD;
                                end
                            end
                        end
                        ACT_LOAD:
                        begin
                            mem_we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_BY0:
            begin
                // Drop rows above or below the window
                alu_req = '{a: oy_reg, b: win_h, inv: 1'b1, cin: 1'b1};
                if (oy_reg[DW-1] || !alu_res.neg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_BNEAR;
                end
            end

            S_BNEAR:
            begin
                alu_req = '{a: word_t'(chh), b: oy_reg, inv: 1'b1, cin: 1'b1};
                state_next = alu_res.neg ? S_BY1 : S_BDOWN;
            end

            S_BDOWN:
            begin
                // Nudge down by the cell height plus one
                alu_req    = '{a: oy_reg, b: word_t'(chh), inv: 1'b0, cin: 1'b1};
                oy_next    = alu_res.sum;
                state_next = S_BY1;
            end

            S_BY1:
            begin
                alu_req    = '{a: oy_reg, b: win_h, inv: 1'b1, cin: 1'b1};
                state_next = alu_res.neg ? S_BX : S_IDLE;
            end

            S_BX:
            begin
                // Right edge minus start column minus one must stay positive
                alu_req = '{a: win_w, b: ox_reg, inv: 1'b1, cin: 1'b0};
                if (alu_res.neg || alu_res.zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    acc_next   = ox_reg;
                    bit_next   = '0;
                    state_next = S_BMUL;
                end
            end

            S_BMUL:
            begin
                // Shift-add string end column: start + length * cell width
                alu_req.a   = acc_reg;
                alu_req.b   = len_reg[bit_reg] ? (word_t'(chw) << bit_reg) : '0;
                alu_req.inv = 1'b0;
                alu_req.cin = 1'b0;
                acc_next    = alu_res.sum;
                bit_next    = bit_reg + 1'b1;
                if (&bit_reg)
                begin
                    state_next = S_BSKIP;
                end
            end

            S_BSKIP:
            begin
                // Skip leading characters left of column zero
                alu_req = '{a: ox_reg, b: word_t'(chw), inv: 1'b0, cin: 1'b0};
                if (acc_reg[DW-1] || (acc_reg == '0))
                begin
                    state_next = S_IDLE;
                end
                else if (ox_reg[DW-1] && (len_reg != '0))
                begin
                    ox_next   = alu_res.sum;
                    skip_next = skip_reg + 1'b1;
                    len_next  = len_reg - 1'b1;
                end
                else if (len_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_BTRIM;
                end
            end

            S_BTRIM:
            begin
                // Trim trailing characters past the right edge
                alu_req = '{a: acc_reg, b: win_w, inv: 1'b1, cin: 1'b1};
                if (!alu_res.neg && (len_reg != '0))
                begin
                    state_next = S_BSUB;
                end
                else
                begin
                    state_next = S_IDLE;
                    if (len_reg != '0)
                    begin
                        skip_cnt_next   = skip_reg;
                        render_cnt_next = len_reg;
                        pen_x_next      = ox_reg[COORD_BITS-1:0];
                        pen_y_next      = oy_reg[COORD_BITS-1:0];
                        pen_z_next      = z_reg;
                        visible_next    = 1'b1;
                    end
                end
            end

            S_BSUB:
            begin
                alu_req    = '{a: acc_reg, b: word_t'(chw), inv: 1'b1, cin: 1'b1};
                acc_next   = alu_res.sum;
                len_next   = len_reg - 1'b1;
                state_next = S_BTRIM;
            end

            S_DRD:
            begin
                // Table read in flight
                state_next = S_DOP;
            end

            S_DOP:
            begin
                alu_req = '{a: word_t'(pen_x_reg), b: sdx, inv: 1'b0, cin: 1'b0};
                op_next = ent_op;
                dy_next = mem_rdata[15:8];
                x1_next = alu_res.sum[COORD_BITS-1:0];
                case (ent_op)
                    OP_END:
                    begin
                        state_next = S_DEND;
                    end
                    OP_DRAW, OP_MOVE:
                    begin
                        state_next = S_DY;
                    end
                    default:
                    begin
                        idx_next   = adv_idx;
                        state_next = adv_state;
                    end
                endcase
            end

            S_DY:
            begin
                // Y is inverted: subtract the offset
                alu_req    = '{a: word_t'(pen_y_reg), b: sdy, inv: 1'b1, cin: 1'b1};
                pen_x_next = x1_reg;
                pen_y_next = alu_res.sum[COORD_BITS-1:0];
                if (op_reg == OP_DRAW)
                begin
                    new_next = '{x0: pen_x_reg, y0: pen_y_reg, x1: x1_reg,
                                 y1: alu_res.sum[COORD_BITS-1:0], z: pen_z_reg,
                                 last: 1'b0};
                    state_next = S_DPUSH;
                end
                else
                begin
                    idx_next   = adv_idx;
                    state_next = adv_state;
                end
            end

            S_DPUSH:
            begin
                // Hold one segment back so the final one can be marked
                if (!pend_valid_reg)
                begin
                    pend_next       = new_reg;
                    pend_valid_next = 1'b1;
                    idx_next        = adv_idx;
                    state_next      = adv_state;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    pend_next       = new_reg;
                    idx_next        = adv_idx;
                    state_next      = adv_state;
                end
            end

            S_DEND:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            bit_reg        <= '0;
            len_reg        <= '0;
            skip_reg       <= '0;
            skip_cnt_reg   <= '0;
            render_cnt_reg <= '0;
            char_pos_reg   <= '0;
            visible_reg    <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            pen_z_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            bit_reg        <= bit_next;
            len_reg        <= len_next;
            skip_reg       <= skip_next;
            skip_cnt_reg   <= skip_cnt_next;
            render_cnt_reg <= render_cnt_next;
            char_pos_reg   <= char_pos_next;
            visible_reg    <= visible_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            pen_z_reg      <= pen_z_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        acc_reg  <= acc_next;
        z_reg    <= z_next;
        code_reg <= code_next;
        op_reg   <= op_next;
        dy_reg   <= dy_next;
        x1_reg   <= x1_next;
        new_reg  <= new_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

>>> design/stroke_font_text_clip_render.sv
// Load, ignored and skipped character requests finish in the idle state. A begin request
// checks the rows, may nudge down, checks the column, shift-adds the end column, then skips
// leading and trims trailing chars. A character request walks up to 32 stroke table entries:
// read, x add, y subtract, push for a draw; a push stalls while the output segment waits untaken.
// A segment is held until the next one or the glyph end, then is registered to the output.
// Reset restores config, then clears the 4096-entry table with requests held off.
module stroke_font_text_clip_render
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sfr_item_if.sink    item,
    sfr_seg_if.source   seg,
    sfr_cfg_if.sink     cfg
);

    cfg_t                  cfg_reg, cfg_next;
    item_t                 item_d;
    seg_t                  seg_d;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [ENTRY_BITS-1:0] mem_wdata;
    logic [ADDR_BITS-1:0]  mem_raddr;
    logic [ENTRY_BITS-1:0] mem_rdata;
    alu_req_t              alu_req;
    alu_res_t              alu_res;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WIN_WIDTH:   cfg_next.window_width     = cfg.data;
                REG_WIN_HEIGHT:  cfg_next.window_height    = cfg.data;
                REG_CHAR_WIDTH:  cfg_next.base_char_width  = cfg.data[6:0];
                REG_CHAR_HEIGHT: cfg_next.base_char_height = cfg.data[6:0];
                REG_FONT_SIZE:   cfg_next.font_size        = cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_width     <= 13'd640;
            cfg_reg.window_height    <= 13'd480;
            cfg_reg.base_char_width  <= 7'd8;
            cfg_reg.base_char_height <= 7'd12;
            cfg_reg.font_size        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Gather request fields
    always_comb
    begin
        item_d.action       = item.action;
        item_d.start_x      = item.start_x;
        item_d.start_y      = item.start_y;
        item_d.start_z      = item.start_z;
        item_d.str_length   = item.str_length;
        item_d.char_code    = item.char_code;
        item_d.stroke_index = item.stroke_index;
        item_d.stroke_op    = item.stroke_op;
        item_d.stroke_dx    = item.stroke_dx;
        item_d.stroke_dy    = item.stroke_dy;
    end

    // Drive segment fields
    assign seg.seg_x0       = seg_d.x0;
    assign seg.seg_y0       = seg_d.y0;
    assign seg.seg_x1       = seg_d.x1;
    assign seg.seg_y1       = seg_d.y1;
    assign seg.seg_z        = seg_d.z;
    assign seg.last_segment = seg_d.last;

    sfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_q      (cfg_reg),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .item_d     (item_d),
        .seg_valid  (seg.valid),
        .seg_ready  (seg.ready),
        .seg_d      (seg_d),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .alu_req    (alu_req),
        .alu_res    (alu_res)
    );

    sfr_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    sfr_stroke_mem u_mem (
        .clk       (clk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .raddr     (mem_raddr),
        .rdata_reg (mem_rdata)
    );

endmodule

>>> design/sfr_checker.sv
module sfr_checker
    import sfr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         in_action,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] out_x0,
    input logic signed [15:0] out_y0,
    input logic signed [15:0] out_x1,
    input logic signed [15:0] out_y1,
    input logic signed [15:0] out_z,
    input logic               out_last
);

    // A stalled segment holds
    a_seg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x0) && $stable(out_y0)
            && $stable(out_x1) && $stable(out_y1) && $stable(out_z)
            && $stable(out_last))
        else $error("segment changed while stalled");

    // Begin and load requests never start a segment
    a_no_seg: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action != ACT_CHAR |=> !$rose(out_valid))
        else $error("segment after a non-character request");

    // A non-final segment means a glyph walk is still running
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("ready while a glyph is unfinished");

    // A table load leaves the block ready for the next request
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action == ACT_LOAD |=> in_ready)
        else $error("not ready after a table load");

endmodule

bind stroke_font_text_clip_render sfr_checker u_sfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_action (item.action),
    .out_valid (seg.valid),
    .out_ready (seg.ready),
    .out_x0    (seg.seg_x0),
    .out_y0    (seg.seg_y0),
    .out_x1    (seg.seg_x1),
    .out_y1    (seg.seg_y1),
    .out_z     (seg.seg_z),
    .out_last  (seg.last_segment)
);
